>>> rtl/core/a64_reg_logic_multiply_unit_core_defines.svh
// Assertion macros for the logic and multiply execute core.
`ifndef A64_REG_LOGIC_MULTIPLY_UNIT_CORE_DEFINES_SVH
`define A64_REG_LOGIC_MULTIPLY_UNIT_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define A64LM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define A64LM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define A64LM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define A64LM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/a64lm_pkg.sv
// Shared constants and types of the logic and multiply execute core.
`default_nettype none
package a64lm_pkg;

  localparam int RegWidth   = 64;
  localparam int HalfWidth  = RegWidth / 2;
  localparam int ShiftBits  = $clog2(RegWidth);
  localparam int HShiftBits = $clog2(HalfWidth);

  typedef enum logic [1:0] {
    SHIFT_LSL = 2'd0,
    SHIFT_LSR = 2'd1,
    SHIFT_ASR = 2'd2,
    SHIFT_ROR = 2'd3
  } shift_kind_e;

  typedef struct packed {
    shift_kind_e          kind;
    logic [ShiftBits-1:0] amount;
    logic                 wide;
    logic                 invert;
  } shift_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/core/a64lm_shifter.sv
// Second-operand shifter: LSL, LSR, ASR, ROR and optional invert, 64 or 32 bits.
`default_nettype none
module a64lm_shifter
  import a64lm_pkg::*;
(
  input  logic [RegWidth-1:0] operand_i,
  input  shift_ctrl_t         ctrl_i,
  output logic [RegWidth-1:0] result_o
);

  logic [ShiftBits-1:0]    amt_wide;
  logic [HShiftBits-1:0]   amt_narrow;
  logic [HalfWidth-1:0]    narrow_op;
  logic [2*RegWidth-1:0]   wide_rot;
  logic [RegWidth-1:0]     narrow_rot;
  logic [RegWidth-1:0]     wide_res;
  logic [HalfWidth-1:0]    narrow_res;
  logic [RegWidth-1:0]     shifted;

  always_comb begin
    amt_wide   = ctrl_i.amount;
    amt_narrow = ctrl_i.amount[HShiftBits-1:0];
    narrow_op  = operand_i[HalfWidth-1:0];
    wide_rot   = {operand_i, operand_i} >> amt_wide;
    narrow_rot = {narrow_op, narrow_op} >> amt_narrow;
    case (ctrl_i.kind)
      SHIFT_LSL: begin
        wide_res   = operand_i << amt_wide;
        narrow_res = narrow_op << amt_narrow;
      end
      SHIFT_LSR: begin
        wide_res   = operand_i >> amt_wide;
        narrow_res = narrow_op >> amt_narrow;
      end
      SHIFT_ASR: begin
        wide_res   = RegWidth'($signed(operand_i) >>> amt_wide);
        narrow_res = HalfWidth'($signed(narrow_op) >>> amt_narrow);
      end
      SHIFT_ROR: begin
        wide_res   = wide_rot[RegWidth-1:0];
        narrow_res = narrow_rot[HalfWidth-1:0];
      end
      default: begin
        wide_res   = operand_i;
        narrow_res = narrow_op;
      end
    endcase
    shifted  = ctrl_i.wide ? wide_res : {{HalfWidth{1'b0}}, narrow_res};
    result_o = ctrl_i.invert ? ~shifted : shifted;
  end

endmodule
`default_nettype wire

>>> rtl/core/a64_reg_logic_multiply_unit_core.sv
// Top level: three-stage execute core for ARM64 shifted-register logic and MADD/MSUB.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------------
//  in      | to core   | in_valid_i / in_stall_o   | instr_word, rn_value, rm_value, ra_value
//  out     | from core | out_valid_o / out_stall_i | dest_index, dest_value, write_enable,
//          |           |                           | flags_write, nzcv, status
//
// out_valid_o rises when the word is registered into stage 3; one word enters per cycle while in_stall_o is low.
// Stage 1 decodes, shifts and forms the three 32x32 partial products; stage 2 sums
// the products and applies the logic op; stage 3 accumulates and registers the result.
// Each stage holds while the one after it is full and stalled; empty stages fill.
// Reset clears the stage valid bits only.
`default_nettype none
`include "a64_reg_logic_multiply_unit_core_defines.svh"
module a64_reg_logic_multiply_unit_core
  import a64lm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [31:0]         instr_word_i,
  input  logic [RegWidth-1:0] rn_value_i,
  input  logic [RegWidth-1:0] rm_value_i,
  input  logic [RegWidth-1:0] ra_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [4:0]          dest_index_o,
  output logic [RegWidth-1:0] dest_value_o,
  output logic                write_enable_o,
  output logic                flags_write_o,
  output logic [3:0]          nzcv_o,
  output logic [1:0]          status_o
);

  localparam logic [4:0] ZeroReg         = 5'h1F;
  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusUnhandled = 2'd1;
  localparam logic [1:0] StatusReserved  = 2'd2;
  localparam logic [1:0] OpcAnd          = 2'd0;
  localparam logic [1:0] OpcOrr          = 2'd1;
  localparam logic [1:0] OpcEor          = 2'd2;
  localparam logic [1:0] OpcAnds         = 2'd3;
  localparam logic [3:0] OprMul          = 4'b1000;

  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_LOGIC = 2'd1,
    CLS_MUL  = 2'd2,
    CLS_RSVD = 2'd3
  } op_class_e;

  // decode
  logic [4:0]          rd;
  logic [4:0]          rn_idx;
  logic [5:0]          imm6;
  logic [4:0]          rm_idx;
  logic [3:0]          opr;
  logic                m_bit;
  logic [1:0]          opc;
  logic                sf;
  logic [RegWidth-1:0] rn_op;
  logic [RegWidth-1:0] rm_op;
  logic [RegWidth-1:0] ra_op;
  op_class_e           cls;
  shift_ctrl_t         sh_ctrl;
  logic [RegWidth-1:0] op2;

  // handshake
  logic s1_en, s2_en, s3_en;
  logic s1_valid_q, s2_valid_q, s3_valid_q;

  // stage 1
  op_class_e            s1_cls_q;
  logic [4:0]           s1_rd_q;
  logic [1:0]           s1_opc_q;
  logic                 s1_sf_q;
  logic                 s1_sub_q;
  logic [RegWidth-1:0]  s1_ra_q;
  logic [RegWidth-1:0]  s1_rn_q;
  logic [RegWidth-1:0]  s1_op2_q;
  logic [RegWidth-1:0]  s1_pll_d, s1_pll_q;
  logic [HalfWidth-1:0] s1_plh_d, s1_plh_q;
  logic [HalfWidth-1:0] s1_phl_d, s1_phl_q;

  // stage 2
  op_class_e            s2_cls_q;
  logic [4:0]           s2_rd_q;
  logic [1:0]           s2_opc_q;
  logic                 s2_sf_q;
  logic                 s2_sub_q;
  logic [RegWidth-1:0]  s2_ra_q;
  logic [HalfWidth-1:0] cross_sum;
  logic [RegWidth-1:0]  s2_prod_d, s2_prod_q;
  logic [RegWidth-1:0]  logic_raw;
  logic [RegWidth-1:0]  s2_logic_d, s2_logic_q;

  // stage 3
  logic [RegWidth-1:0] mul_raw;
  logic [RegWidth-1:0] mul_val;
  logic [RegWidth-1:0] res_val;
  logic                have;
  logic                we;
  logic                fw;
  logic                nbit;
  logic [4:0]          dest_index_d;
  logic [RegWidth-1:0] dest_value_d;
  logic                write_enable_d;
  logic                flags_write_d;
  logic [3:0]          nzcv_d;
  logic [1:0]          status_d;
  logic [4:0]          dest_index_q;
  logic [RegWidth-1:0] dest_value_q;
  logic                write_enable_q;
  logic                flags_write_q;
  logic [3:0]          nzcv_q;
  logic [1:0]          status_q;

  assign s3_en      = !s3_valid_q || !out_stall_i;
  assign s2_en      = !s2_valid_q || s3_en;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_stall_o = !s1_en;

  always_comb begin
    rd     = instr_word_i[4:0];
    rn_idx = instr_word_i[9:5];
    imm6   = instr_word_i[15:10];
    rm_idx = instr_word_i[20:16];
    opr    = instr_word_i[24:21];
    m_bit  = instr_word_i[28];
    opc    = instr_word_i[30:29];
    sf     = instr_word_i[31];
    rn_op  = (rn_idx == ZeroReg) ? '0 : rn_value_i;
    rm_op  = (rm_idx == ZeroReg) ? '0 : rm_value_i;
    ra_op  = (imm6[4:0] == ZeroReg) ? '0 : ra_value_i;
    if (!m_bit && !opr[3]) begin
      cls = (!sf && imm6[5]) ? CLS_RSVD : CLS_LOGIC;
    end else if (m_bit && opr == OprMul) begin
      cls = CLS_MUL;
    end else begin
      cls = CLS_NONE;
    end
    sh_ctrl.kind   = shift_kind_e'(opr[2:1]);
    sh_ctrl.amount = imm6;
    sh_ctrl.wide   = sf;
    sh_ctrl.invert = opr[0];
    s1_pll_d = RegWidth'(rn_op[HalfWidth-1:0]) * RegWidth'(rm_op[HalfWidth-1:0]);
    s1_plh_d = HalfWidth'(rn_op[HalfWidth-1:0] * rm_op[RegWidth-1:HalfWidth]);
    s1_phl_d = HalfWidth'(rn_op[RegWidth-1:HalfWidth] * rm_op[HalfWidth-1:0]);
  end

  a64lm_shifter u_shifter (
    .operand_i (rm_op),
    .ctrl_i    (sh_ctrl),
    .result_o  (op2)
  );

  always_comb begin
    cross_sum = s1_plh_q + s1_phl_q;
    s2_prod_d = s1_pll_q + {cross_sum, {HalfWidth{1'b0}}};
    case (s1_opc_q)
      OpcAnd:  logic_raw = s1_rn_q & s1_op2_q;
      OpcOrr:  logic_raw = s1_rn_q | s1_op2_q;
      OpcEor:  logic_raw = s1_rn_q ^ s1_op2_q;
      OpcAnds: logic_raw = s1_rn_q & s1_op2_q;
      default: logic_raw = s1_rn_q & s1_op2_q;
    endcase
    s2_logic_d = s1_sf_q ? logic_raw : {{HalfWidth{1'b0}}, logic_raw[HalfWidth-1:0]};
  end

  always_comb begin
    mul_raw = s2_sub_q ? (s2_ra_q - s2_prod_q) : (s2_ra_q + s2_prod_q);
    mul_val = s2_sf_q ? mul_raw : {{HalfWidth{1'b0}}, mul_raw[HalfWidth-1:0]};
    res_val = (s2_cls_q == CLS_LOGIC) ? s2_logic_q : mul_val;
    have    = (s2_cls_q == CLS_LOGIC) || (s2_cls_q == CLS_MUL);
    we      = have && (s2_rd_q != ZeroReg);
    fw      = (s2_cls_q == CLS_LOGIC) && (s2_opc_q == OpcAnds);
    nbit    = s2_sf_q ? res_val[RegWidth-1] : res_val[HalfWidth-1];
    dest_index_d   = we ? s2_rd_q : '0;
    dest_value_d   = we ? res_val : '0;
    write_enable_d = we;
    flags_write_d  = fw;
    nzcv_d         = fw ? {nbit, (res_val == '0), 2'b00} : 4'd0;
    case (s2_cls_q)
      CLS_LOGIC: status_d = StatusOk;
      CLS_MUL:   status_d = StatusOk;
      CLS_RSVD:  status_d = StatusReserved;
      CLS_NONE:  status_d = StatusUnhandled;
      default:   status_d = StatusUnhandled;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_en) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      s1_cls_q <= cls;
      s1_rd_q  <= rd;
      s1_opc_q <= opc;
      s1_sf_q  <= sf;
      s1_sub_q <= imm6[5];
      s1_ra_q  <= ra_op;
      s1_rn_q  <= rn_op;
      s1_op2_q <= op2;
      s1_pll_q <= s1_pll_d;
      s1_plh_q <= s1_plh_d;
      s1_phl_q <= s1_phl_d;
    end
    if (s2_en && s1_valid_q) begin
      s2_cls_q   <= s1_cls_q;
      s2_rd_q    <= s1_rd_q;
      s2_opc_q   <= s1_opc_q;
      s2_sf_q    <= s1_sf_q;
      s2_sub_q   <= s1_sub_q;
      s2_ra_q    <= s1_ra_q;
      s2_prod_q  <= s2_prod_d;
      s2_logic_q <= s2_logic_d;
    end
    if (s3_en && s2_valid_q) begin
      dest_index_q   <= dest_index_d;
      dest_value_q   <= dest_value_d;
      write_enable_q <= write_enable_d;
      flags_write_q  <= flags_write_d;
      nzcv_q         <= nzcv_d;
      status_q       <= status_d;
    end
  end

  assign out_valid_o    = s3_valid_q;
  assign dest_index_o   = dest_index_q;
  assign dest_value_o   = dest_value_q;
  assign write_enable_o = write_enable_q;
  assign flags_write_o  = flags_write_q;
  assign nzcv_o         = nzcv_q;
  assign status_o       = status_q;

  `A64LM_ASSERT_NOW(a_write_ok, clk_i, rst_ni, out_valid_o && write_enable_o,
                    (status_o == StatusOk) && (dest_index_o != ZeroReg))
  `A64LM_ASSERT_NOW(a_flags_ok, clk_i, rst_ni, out_valid_o && flags_write_o,
                    (status_o == StatusOk) && (nzcv_o[1:0] == 2'b00))
  `A64LM_ASSERT_NOW(a_stall_full, clk_i, rst_ni, in_stall_o,
                    s1_valid_q && s2_valid_q && s3_valid_q && out_stall_i)
  `A64LM_ASSERT_NEXT(a_s1_hold, clk_i, rst_ni, s1_valid_q && !s2_en,
                     s1_valid_q && $stable(s1_rd_q))

endmodule
`default_nettype wire
